// ===== src/apct_pkg.sv =====
package apct_pkg;
  localparam int NUM_SLOTS = 32;
  localparam int NUM_TYPES = 32;
  localparam int COORD_BITS = 16;
  localparam int SLOT_BITS = 5;
  localparam int TYPE_BITS = 5;
  localparam int MAX_OUT = 62;

  localparam logic [2:0] MODE_MASK = 3'd0;
  localparam logic [2:0] MODE_ADD = 3'd1;
  localparam logic [2:0] MODE_MARK = 3'd2;
  localparam logic [2:0] MODE_PURGE = 3'd3;
  localparam logic [2:0] MODE_SCAN = 3'd4;
  localparam logic [2:0] MODE_CLEAR = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [COORD_BITS-2:0] w;
    logic [COORD_BITS-2:0] h;
  } rect_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [4:0] slot;
    logic [4:0] obj_type;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic [14:0] rect_w;
    logic [14:0] rect_h;
    logic notify;
    logic [31:0] mask_word;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] reporter_slot;
    logic [4:0] other_slot;
    logic hit;
    logic last;
  } res_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic add;
    logic clear;
    logic purge;
    logic mark;
    logic [SLOT_BITS-1:0] mark_slot;
    logic [TYPE_BITS-1:0] typ;
    rect_t rect;
    logic notify;
  } cell_ctl_t;

  // per-cell view read by the controller
  typedef struct packed {
    logic occ;
    logic lst;
    logic [TYPE_BITS-1:0] typ;
    rect_t rect;
  } cell_view_t;
endpackage

// ===== src/apct_if.sv =====
interface apct_cmd_if;
  import apct_pkg::*;
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface apct_res_if;
  import apct_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/apct_cell.sv =====
module apct_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [apct_pkg::SLOT_BITS-1:0] idx_i,
  input  apct_pkg::cell_ctl_t          ctl_i,
  input  logic                         add_here_i,
  input  logic                         free_in_i,
  output logic                         free_out_o,
  output apct_pkg::cell_view_t         view_o
);
  import apct_pkg::*;

  logic occ_q, pend_q, lst_q;
  logic [TYPE_BITS-1:0] typ_q;
  rect_t rect_q;

  // free chain: true once this cell or any lower cell is free
  assign free_out_o = free_in_i | ~occ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      pend_q <= 1'b0;
      lst_q <= 1'b0;
    end else if (ctl_i.clear) begin
      occ_q <= 1'b0;
      pend_q <= 1'b0;
      lst_q <= 1'b0;
    end else if (ctl_i.add && add_here_i) begin
      occ_q <= 1'b1;
      pend_q <= 1'b0;
      lst_q <= ctl_i.notify;
    end else if (ctl_i.purge && occ_q && pend_q) begin
      occ_q <= 1'b0;
      pend_q <= 1'b0;
      lst_q <= 1'b0;
    end else if (ctl_i.mark && ctl_i.mark_slot == idx_i && occ_q) begin
      pend_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.add && add_here_i) begin
      typ_q <= ctl_i.typ;
      rect_q <= ctl_i.rect;
    end
  end

  assign view_o = '{occ: occ_q, lst: lst_q, typ: typ_q, rect: rect_q};
endmodule

// ===== src/apct_pair_test.sv =====
module apct_pair_test (
  input  apct_pkg::cell_view_t a_i,
  input  apct_pkg::cell_view_t b_i,
  input  logic [31:0]          mask_a_i,
  input  logic [31:0]          mask_b_i,
  output logic                 ab_o,
  output logic                 ba_o
);
  import apct_pkg::*;

  logic signed [COORD_BITS:0] ax0, ax1, bx0, bx1, ay0, ay1, by0, by1;
  logic ovl;

  always_comb begin
    ax0 = (COORD_BITS+1)'(a_i.rect.x);
    ax1 = (COORD_BITS+1)'(a_i.rect.x) + (COORD_BITS+1)'({2'b00, a_i.rect.w});
    bx0 = (COORD_BITS+1)'(b_i.rect.x);
    bx1 = (COORD_BITS+1)'(b_i.rect.x) + (COORD_BITS+1)'({2'b00, b_i.rect.w});
    ay0 = (COORD_BITS+1)'(a_i.rect.y);
    ay1 = (COORD_BITS+1)'(a_i.rect.y) + (COORD_BITS+1)'({2'b00, a_i.rect.h});
    by0 = (COORD_BITS+1)'(b_i.rect.y);
    by1 = (COORD_BITS+1)'(b_i.rect.y) + (COORD_BITS+1)'({2'b00, b_i.rect.h});
    ovl = (ax0 < bx1) && (ax1 > bx0) && (ay0 < by1) && (ay1 > by0);
    ab_o = b_i.occ && ovl && a_i.lst && mask_a_i[b_i.typ];
    ba_o = b_i.occ && ovl && b_i.lst && mask_b_i[a_i.typ];
  end
endmodule

// ===== src/aabb_pair_collision_table_core.sv =====
// AABB pair collision table.
// Channels: cmd_i (sink) takes one command item, res_o (source) returns the
// result items for it, the final one flagged by last. Valid/ready handshake.
// Mask write, add, mark, purge, clear and unused codes: one result, valid
// in the cycle after acceptance.
// Scan of slot s: the walk checks one pair direction per cycle while the
// receiver does not stall, both directions for every partner slot above
// s, and holds each report for a look ahead that settles its last flag.
// A scan gives at most 62-2*s reports. An empty slot or slot 31 answers
// in the cycle after acceptance. A scan with no contact returns one plain
// ok item. One command is worked on at a time: the next is taken at the
// earliest in the cycle after its last result is accepted.
// Reset clears occupancy, listener and pending bits and the pair mask.
// A stalled receiver holds the result register; the walk waits with it.
module aabb_pair_collision_table_core (
  input  logic clk_i,
  input  logic rst_ni,
  apct_cmd_if.sink   cmd_i,
  apct_res_if.source res_o
);
  import apct_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} state_e;
  state_e state_q;

  cmd_t cmd_q;
  logic [31:0] mask_q [NUM_TYPES];
  cell_view_t view [NUM_SLOTS];
  logic [NUM_SLOTS:0] free_c;
  cell_ctl_t ctl;
  logic [SLOT_BITS-1:0] k_q;
  logic phase_q;
  logic [5:0] n_q;
  res_t res_q;
  logic rv_q;

  logic acc;
  assign acc = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready = (state_q == S_IDLE) && !rv_q;
  assign res_o.valid = rv_q;
  assign res_o.data = res_q;

  logic [SLOT_BITS-1:0] free_idx;
  always_comb begin
    free_idx = '0;
    for (int i = NUM_SLOTS-1; i >= 0; i--) if (!view[i].occ) free_idx = SLOT_BITS'(i);
  end

  always_comb begin
    ctl = '0;
    ctl.add = acc && cmd_i.data.mode == MODE_ADD;
    ctl.clear = acc && cmd_i.data.mode == MODE_CLEAR;
    ctl.purge = acc && cmd_i.data.mode == MODE_PURGE;
    ctl.mark = acc && cmd_i.data.mode == MODE_MARK;
    ctl.mark_slot = cmd_i.data.slot;
    ctl.typ = cmd_i.data.obj_type;
    ctl.rect = '{x: cmd_i.data.rect_x, y: cmd_i.data.rect_y,
                 w: cmd_i.data.rect_w, h: cmd_i.data.rect_h};
    ctl.notify = cmd_i.data.notify;
  end

  assign free_c[0] = 1'b0;
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    apct_cell u_cell (
      .clk_i, .rst_ni,
      .idx_i(SLOT_BITS'(g)), .ctl_i(ctl),
      .add_here_i(!free_c[g] && !view[g].occ),
      .free_in_i(free_c[g]), .free_out_o(free_c[g+1]),
      .view_o(view[g])
    );
  end

  cell_view_t va, vb;
  assign va = view[cmd_q.slot];
  assign vb = view[k_q];
  logic ab, ba;
  apct_pair_test u_pair (
    .a_i(va), .b_i(vb),
    .mask_a_i(mask_q[va.typ]), .mask_b_i(mask_q[vb.typ]),
    .ab_o(ab), .ba_o(ba)
  );

  logic k_end;
  assign k_end = (k_q == SLOT_BITS'(NUM_SLOTS-1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rv_q <= 1'b0;
      k_q <= '0;
      phase_q <= 1'b0;
      n_q <= '0;
      for (int t = 0; t < NUM_TYPES; t++) mask_q[t] <= '0;
    end else begin
      if (rv_q && res_o.ready) rv_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (acc) begin
          res_t r;
          r = '{status: ST_OK, reporter_slot: '0, other_slot: '0,
                hit: 1'b0, last: 1'b1};
          cmd_q <= cmd_i.data;
          unique case (cmd_i.data.mode)
            MODE_MASK: begin
              mask_q[cmd_i.data.obj_type] <= cmd_i.data.mask_word;
              rv_q <= 1'b1;
            end
            MODE_ADD: begin
              if (free_c[NUM_SLOTS]) r.reporter_slot = free_idx;
              else r.status = ST_FULL;
              rv_q <= 1'b1;
            end
            MODE_MARK: begin
              if (!view[cmd_i.data.slot].occ) r.status = ST_EMPTY;
              rv_q <= 1'b1;
            end
            MODE_SCAN: begin
              if (!view[cmd_i.data.slot].occ) begin
                r.status = ST_EMPTY;
                rv_q <= 1'b1;
              end else if (cmd_i.data.slot == SLOT_BITS'(NUM_SLOTS-1)) begin
                rv_q <= 1'b1;
              end else begin
                k_q <= cmd_i.data.slot + 1'b1;
                phase_q <= 1'b0;
                n_q <= '0;
                state_q <= S_SCAN;
              end
            end
            default: rv_q <= 1'b1;
          endcase
          res_q <= r;
        end
        S_SCAN: if (!rv_q || res_o.ready) begin
          logic fire, more_b;
          fire = (phase_q ? ba : ab) && (n_q < 6'(MAX_OUT));
          more_b = !phase_q;
          if (fire) begin
            // last decided when next report known; emit as pending then patch
            res_q <= '{status: ST_OK,
                       reporter_slot: phase_q ? k_q : cmd_q.slot,
                       other_slot: phase_q ? cmd_q.slot : k_q,
                       hit: 1'b1, last: 1'b0};
            n_q <= n_q + 1'b1;
          end
          if (more_b) phase_q <= 1'b1;
          else begin
            phase_q <= 1'b0;
            k_q <= k_q + 1'b1;
          end
          // hold output until scan decides last: stage report in S_OUT flow
          if (fire) begin
            state_q <= S_OUT;
          end else if (!more_b && k_end) begin
            // only reached before the first report: no contact at all
            res_q <= '{status: ST_OK, reporter_slot: '0, other_slot: '0,
                       hit: 1'b0, last: 1'b1};
            rv_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_OUT: begin
          // res_q holds a report; look ahead for another one before releasing it
          logic nxt, done;
          nxt = (phase_q ? ba : ab) && (n_q < 6'(MAX_OUT));
          done = phase_q && k_end && !nxt;
          if (!(phase_q == 1'b0 && k_q == '0)) begin
            if (nxt || (phase_q ? k_end : 1'b0) || done) begin
              rv_q <= 1'b1;
              res_q.last <= !nxt;
              state_q <= nxt ? S_SCAN : S_IDLE;
            end else begin
              if (!phase_q) phase_q <= 1'b1;
              else begin
                phase_q <= 1'b0;
                k_q <= k_q + 1'b1;
              end
            end
          end else begin
            // walked past the top slot
            rv_q <= 1'b1;
            res_q.last <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== dv/tb_aabb_pair_collision_table_core.sv =====
`timescale 1ns / 100ps
module tb_aabb_pair_collision_table_core;
  import apct_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #1 clk_i = ~clk_i;

  apct_cmd_if cmd_if ();
  apct_res_if res_if ();

  aabb_pair_collision_table_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if.sink),
    .res_o  (res_if.source)
  );

  // shadow of the table
  logic        occ_q  [NUM_SLOTS];
  logic        del_q  [NUM_SLOTS];
  logic        lst_q  [NUM_SLOTS];
  logic [4:0]  typ_q  [NUM_SLOTS];
  rect_t       rect_q [NUM_SLOTS];
  logic [31:0] pmask_q[NUM_TYPES];

  res_t expected_q[$];
  int   errors = 0;
  int   n_results = 0;
  int   n_hits = 0;
  int   n_sent = 0;
  longint cycles = 0;
  int   burst_left = 0;

  function automatic bit boxes_touch(int a, int b);
    longint ax, ay, aw, ah, bx, by, bw, bh;
    ax = rect_q[a].x; ay = rect_q[a].y; aw = rect_q[a].w; ah = rect_q[a].h;
    bx = rect_q[b].x; by = rect_q[b].y; bw = rect_q[b].w; bh = rect_q[b].h;
    return ax < bx + bw && ax + aw > bx && ay < by + bh && ay + ah > by;
  endfunction

  function automatic void push_res(logic [1:0] st, logic [4:0] rs, logic [4:0] os,
                                   logic h, logic l);
    res_t r;
    r.status = st; r.reporter_slot = rs; r.other_slot = os; r.hit = h; r.last = l;
    expected_q.push_back(r);
  endfunction

  function automatic void predict_command(cmd_t c);
    int n;
    int s;
    bit done;
    n = 0;
    s = c.slot;
    done = 0;
    case (c.mode)
      MODE_MASK: begin
        pmask_q[c.obj_type] = c.mask_word;
        push_res(ST_OK, 0, 0, 0, 1);
      end
      MODE_ADD: begin
        for (int i = 0; i < NUM_SLOTS && !done; i++) begin
          if (!occ_q[i]) begin
            occ_q[i] = 1; del_q[i] = 0; lst_q[i] = c.notify; typ_q[i] = c.obj_type;
            rect_q[i].x = c.rect_x; rect_q[i].y = c.rect_y;
            rect_q[i].w = c.rect_w; rect_q[i].h = c.rect_h;
            push_res(ST_OK, i[4:0], 0, 0, 1);
            done = 1;
          end
        end
        if (!done) push_res(ST_FULL, 0, 0, 0, 1);
      end
      MODE_MARK: begin
        if (!occ_q[s]) push_res(ST_EMPTY, 0, 0, 0, 1);
        else begin
          del_q[s] = 1;
          push_res(ST_OK, 0, 0, 0, 1);
        end
      end
      MODE_PURGE: begin
        for (int i = 0; i < NUM_SLOTS; i++)
          if (occ_q[i] && del_q[i]) begin
            occ_q[i] = 0; del_q[i] = 0; lst_q[i] = 0;
          end
        push_res(ST_OK, 0, 0, 0, 1);
      end
      MODE_SCAN: begin
        if (!occ_q[s]) push_res(ST_EMPTY, 0, 0, 0, 1);
        else begin
          for (int k = s + 1; k < NUM_SLOTS; k++) begin
            if (occ_q[k] && boxes_touch(s, k)) begin
              if (n < MAX_OUT && lst_q[s] && pmask_q[typ_q[s]][typ_q[k]]) begin
                push_res(ST_OK, s[4:0], k[4:0], 1, 0); n++;
              end
              if (n < MAX_OUT && lst_q[k] && pmask_q[typ_q[k]][typ_q[s]]) begin
                push_res(ST_OK, k[4:0], s[4:0], 1, 0); n++;
              end
            end
          end
          if (n == 0) push_res(ST_OK, 0, 0, 0, 1);
          else expected_q[$].last = 1;
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          occ_q[i] = 0; del_q[i] = 0; lst_q[i] = 0;
        end
        push_res(ST_OK, 0, 0, 0, 1);
      end
      default: push_res(ST_OK, 0, 0, 0, 1);
    endcase
  endfunction

  // bursts of random length with random gaps
  task automatic send_cmd(cmd_t c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= c;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    predict_command(c);
    n_sent++;
  endtask

  function automatic cmd_t rand_cmd(logic [2:0] mode);
    cmd_t c;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    c = raw[$bits(cmd_t)-1:0];
    c.mode = mode;
    return c;
  endfunction

  function automatic cmd_t small_box(logic [4:0] t, logic nt);
    cmd_t c;
    c = rand_cmd(MODE_ADD);
    c.obj_type = t; c.notify = nt;
    c.rect_x = $signed(16'($urandom_range(0, 60))) - 16'sd30;
    c.rect_y = $signed(16'($urandom_range(0, 60))) - 16'sd30;
    c.rect_w = 15'($urandom_range(0, 40));
    c.rect_h = 15'($urandom_range(0, 40));
    return c;
  endfunction

  // receiver stall pattern
  logic [7:0] stall_lfsr = 8'hA5;
  always @(posedge clk_i) begin
    stall_lfsr <= {stall_lfsr[6:0], stall_lfsr[7] ^ stall_lfsr[5] ^ stall_lfsr[4]
                   ^ stall_lfsr[3]};
    res_if.ready <= (cycles % 400 < 150) ? 1'b1 : (stall_lfsr[2:0] != 3'd0);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && res_if.valid && res_if.ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, res_if.data);
        errors++;
      end else begin
        res_t e;
        e = expected_q.pop_front();
        if (res_if.data.hit) n_hits++;
        if (e !== res_if.data) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, res_if.data);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic test_mask_and_misc();
    cmd_t c;
    c = rand_cmd(MODE_MASK); c.obj_type = 0; c.mask_word = 32'hFFFF_FFFF; send_cmd(c);
    c = rand_cmd(MODE_MASK); c.obj_type = 31; c.mask_word = 32'h8000_0001; send_cmd(c);
    c = rand_cmd(MODE_MASK); c.obj_type = 1; c.mask_word = 32'h0; send_cmd(c);
    c = rand_cmd(3'd6); send_cmd(c);
    c = rand_cmd(3'd7); send_cmd(c);
    c = rand_cmd(MODE_SCAN); c.slot = 0; send_cmd(c);
    c = rand_cmd(MODE_MARK); c.slot = 31; send_cmd(c);
  endtask

  task automatic test_directed_boxes();
    cmd_t c;
    // extreme coordinates and sizes
    c = small_box(0, 1); c.rect_x = 16'sh8000; c.rect_y = 16'sh8000;
    c.rect_w = 15'h7FFF; c.rect_h = 15'h7FFF; send_cmd(c);
    c = small_box(0, 1); c.rect_x = 16'sd32767; c.rect_y = 16'sd32767;
    c.rect_w = 15'h7FFF; c.rect_h = 15'h7FFF; send_cmd(c);
    c = small_box(31, 1); c.rect_x = -16'sd10; c.rect_y = -16'sd10; send_cmd(c);
    c = small_box(0, 0); c.rect_x = 0; c.rect_y = 0; c.rect_w = 0; send_cmd(c);
    // touching edges do not overlap
    c = small_box(0, 1); c.rect_x = 100; c.rect_y = 100; c.rect_w = 10; c.rect_h = 10;
    send_cmd(c);
    c = small_box(0, 1); c.rect_x = 110; c.rect_y = 100; c.rect_w = 10; c.rect_h = 10;
    send_cmd(c);
    for (int s = 0; s < 6; s++) begin
      c = rand_cmd(MODE_SCAN); c.slot = s; send_cmd(c);
    end
    c = rand_cmd(MODE_MARK); c.slot = 2; send_cmd(c);
    send_cmd(c); // already marked
    c = rand_cmd(MODE_SCAN); c.slot = 0; send_cmd(c); // marked still scanned
    c = rand_cmd(MODE_PURGE); send_cmd(c);
    c = rand_cmd(MODE_SCAN); c.slot = 2; send_cmd(c);
  endtask

  task automatic test_full_table();
    cmd_t c;
    c = rand_cmd(MODE_CLEAR); send_cmd(c);
    c = rand_cmd(MODE_MASK); c.obj_type = 3; c.mask_word = 32'hFFFF_FFFF; send_cmd(c);
    for (int i = 0; i < NUM_SLOTS + 1; i++) begin
      c = small_box(3, 1); c.rect_x = 0; c.rect_y = 0; c.rect_w = 5; c.rect_h = 5;
      send_cmd(c);
    end
    c = rand_cmd(MODE_SCAN); c.slot = 0; send_cmd(c); // 62 reports
    c = rand_cmd(MODE_SCAN); c.slot = 31; send_cmd(c);
  endtask

  task automatic test_random();
    cmd_t c;
    int r;
    c = rand_cmd(MODE_CLEAR); send_cmd(c);
    for (int i = 0; i < 68; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        c = rand_cmd(MODE_MASK);
        if ($urandom_range(0, 1)) c.obj_type = 5'($urandom_range(0, 3));
      end else if (r < 45) begin
        c = small_box(5'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end else if (r < 55) begin
        c = rand_cmd(MODE_MARK); c.slot = 5'($urandom_range(0, 12));
      end else if (r < 60) c = rand_cmd(MODE_PURGE);
      else if (r < 90) begin
        c = rand_cmd(MODE_SCAN);
        if ($urandom_range(0, 3) != 0) c.slot = 5'($urandom_range(0, 12));
      end else if (r < 92) c = rand_cmd(MODE_CLEAR);
      else if (r < 94) c = rand_cmd(3'($urandom_range(6, 7)));
      else c = rand_cmd(MODE_ADD);
      send_cmd(c);
    end
  endtask

  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    res_if.ready = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      occ_q[i] = 0; del_q[i] = 0; lst_q[i] = 0; typ_q[i] = 0; rect_q[i] = '0;
    end
    for (int i = 0; i < NUM_TYPES; i++) pmask_q[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_mask_and_misc();
    test_directed_boxes();
    test_full_table();
    test_random();
    wait_drained();
    $display("Sent %0d commands, checked %0d results (%0d contact reports).",
             n_sent, n_results, n_hits);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (cycles > 200000) begin
      $display("FAIL");
      $finish;
    end
  end
endmodule

// ===== files.f =====
src/apct_pkg.sv
src/apct_if.sv
src/apct_cell.sv
src/apct_pair_test.sv
src/aabb_pair_collision_table_core.sv
dv/tb_aabb_pair_collision_table_core.sv
